// ===== hdl/wsdf_pkg.sv =====
// package: result record and constants for the websocket frame deframer
package wsdf_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 24;
   localparam int unsigned OPC_W   = 4;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned ADDR_W  = 3;

   localparam logic [LEN_W-1:0] MAX_BYTES_RESET = LEN_W'(1024 * 1024);

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [OPC_W-1:0] OPC_CONTINUATION = 4'h0;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FRAME_LEN = 2'd1;
   localparam logic [ERR_W-1:0] ERR_MSG_LEN   = 2'd2;

   localparam logic [ADDR_W-1:0] REG_MAX_MESSAGE_BYTES = 3'd0;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              has_data;
      logic [OPC_W-1:0]  message_type;
      logic              is_control;
      logic              last;
      logic [ERR_W-1:0]  error;
   } rsp_type;

endpackage

// ===== hdl/websocket_frame_deframer_unit.sv =====
// websocket frame deframer: header parse, length limits, payload unmasking
//
//   channel  direction  beat
//   req      in         one raw stream byte (req_in_byte)
//   rsp      out        one payload byte, end marker or error record
//   csr      in/out     max_message_bytes at byte address 0
//
// one byte is taken per cycle while req_ready is high; the header, mask and
// payload state update in the same cycle the byte is accepted, and results
// leave from the output register. a second result register catches a result
// while the output is stalled, so req_ready depends only on that register.
// reset is synchronous: parser back to the first header byte, limit 1 MiB.
// after a length error the parser swallows every byte until reset.
module websocket_frame_deframer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [wsdf_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [wsdf_pkg::BYTE_W-1:0]  rsp_data_byte,
   output logic                         rsp_has_data,
   output logic [wsdf_pkg::OPC_W-1:0]   rsp_message_type,
   output logic                         rsp_is_control,
   output logic                         rsp_last,
   output logic [wsdf_pkg::ERR_W-1:0]   rsp_error,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [wsdf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [wsdf_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [wsdf_pkg::CSR_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import wsdf_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_MASK,
      PH_PAYLOAD,
      PH_FAILED
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              fin_ff, fin_in;
   logic [OPC_W-1:0]  opcode_ff, opcode_in;
   logic              masked_ff, masked_in;
   logic [2:0]        count_ff, count_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              over_ff, over_in;
   logic [31:0]       key_ff, key_in;
   logic [1:0]        idx_ff, idx_in;
   logic [LEN_W-1:0]  msg_len_ff, msg_len_in;
   logic [OPC_W-1:0]  msg_op_ff, msg_op_in;
   logic [LEN_W-1:0]  max_ff;

   rsp_type           out_ff, skid_ff, res;
   logic              out_valid_ff, skid_valid_ff;
   logic              accept, push, pop, csr_write;

   // length check inputs, shared by the short and extended length paths
   logic [LEN_W-1:0]  ld_len;
   logic              ld_over;
   logic              ctl;
   logic [LEN_W-1:0]  eff_msg_len;
   logic [LEN_W:0]    msg_sum;
   logic              frame_err, msg_err;
   logic [OPC_W-1:0]  ld_msg_op;
   logic [LEN_W-1:0]  ext_len;
   logic              ext_over;
   logic [BYTE_W-1:0] key_byte;

   assign req_ready  = !skid_valid_ff;
   assign accept     = req_valid && req_ready;
   assign pop        = out_valid_ff && rsp_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MAX_MESSAGE_BYTES) ?
                       {{(CSR_W-LEN_W){1'b0}}, max_ff} : '0;

   assign ctl      = opcode_ff[OPC_W-1];
   assign ext_len  = {len_ff[LEN_W-9:0], req_in_byte};
   assign ext_over = over_ff || (len_ff[LEN_W-1:LEN_W-8] != '0);

   always_comb begin
      if (phase_ff == PH_HDR1) begin
         ld_len  = {{(LEN_W-7){1'b0}}, req_in_byte[6:0]};
         ld_over = 1'b0;
      end else begin
         ld_len  = ext_len;
         ld_over = ext_over;
      end
   end

   assign eff_msg_len = (opcode_ff != OPC_CONTINUATION) ? '0 : msg_len_ff;
   assign msg_sum     = {1'b0, eff_msg_len} + {1'b0, ld_len};
   assign frame_err   = ld_over || (ld_len > max_ff);
   assign msg_err     = !ctl && (msg_sum > {1'b0, max_ff});
   assign ld_msg_op   = (!ctl && opcode_ff != OPC_CONTINUATION) ? opcode_ff : msg_op_ff;

   always_comb begin
      unique case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!masked_ff) begin
         key_byte = '0;
      end
   end

   always_comb begin
      logic             do_len;
      logic             do_start;
      logic [LEN_W-1:0] sp_len;
      logic [OPC_W-1:0] sp_msg_op;

      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      masked_in  = masked_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      over_in    = over_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      msg_len_in = msg_len_ff;
      msg_op_in  = msg_op_ff;
      push       = 1'b0;
      res        = '0;
      do_len     = 1'b0;
      do_start   = 1'b0;
      sp_len     = len_ff;
      sp_msg_op  = msg_op_ff;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = req_in_byte[7];
               opcode_in = req_in_byte[OPC_W-1:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = req_in_byte[7];
               if (req_in_byte[6:0] == LEN7_EXT16 || req_in_byte[6:0] == LEN7_EXT64) begin
                  count_in = (req_in_byte[6:0] == LEN7_EXT16) ? 3'd1 : 3'd7;
                  len_in   = '0;
                  over_in  = 1'b0;
                  phase_in = PH_EXT;
               end else begin
                  do_len = 1'b1;
               end
            end
            PH_EXT: begin
               len_in  = ext_len;
               over_in = ext_over;
               if (count_ff == '0) begin
                  do_len = 1'b1;
               end else begin
                  count_in = count_ff - 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], req_in_byte};
               if (count_ff == '0) begin
                  do_start = 1'b1;
               end else begin
                  count_in = count_ff - 3'd1;
               end
            end
            PH_PAYLOAD: begin
               push             = 1'b1;
               res.data_byte    = req_in_byte ^ key_byte;
               res.has_data     = 1'b1;
               res.message_type = ctl ? opcode_ff : msg_op_ff;
               res.is_control   = ctl;
               idx_in           = idx_ff + 2'd1;
               len_in           = len_ff - LEN_W'(1);
               if (len_ff == LEN_W'(1)) begin
                  res.last = ctl || fin_ff;
                  phase_in = PH_HDR0;
                  if (!ctl && fin_ff) begin
                     msg_op_in  = '0;
                     msg_len_in = '0;
                  end
               end
            end
            default: begin
               phase_in = PH_FAILED;
            end
         endcase

         if (do_len) begin
            priority if (frame_err) begin
               phase_in  = PH_FAILED;
               push      = 1'b1;
               res.error = ERR_FRAME_LEN;
            end else if (msg_err) begin
               phase_in  = PH_FAILED;
               push      = 1'b1;
               res.error = ERR_MSG_LEN;
            end else begin
               if (!ctl) begin
                  msg_op_in  = ld_msg_op;
                  msg_len_in = msg_sum[LEN_W-1:0];
               end
               len_in = ld_len;
               if ((phase_ff == PH_HDR1) ? req_in_byte[7] : masked_ff) begin
                  count_in = 3'd3;
                  phase_in = PH_MASK;
               end else begin
                  do_start  = 1'b1;
                  sp_len    = ld_len;
                  sp_msg_op = ld_msg_op;
               end
            end
         end

         if (do_start) begin
            idx_in = '0;
            if (sp_len != '0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = PH_HDR0;
               if (ctl) begin
                  push             = 1'b1;
                  res.message_type = opcode_ff;
                  res.is_control   = 1'b1;
                  res.last         = 1'b1;
               end else if (fin_ff) begin
                  push             = 1'b1;
                  res.message_type = sp_msg_op;
                  res.last         = 1'b1;
                  msg_op_in        = '0;
                  msg_len_in       = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         fin_ff        <= 1'b0;
         opcode_ff     <= '0;
         masked_ff     <= 1'b0;
         count_ff      <= '0;
         len_ff        <= '0;
         over_ff       <= 1'b0;
         idx_ff        <= '0;
         msg_len_ff    <= '0;
         msg_op_ff     <= '0;
         max_ff        <= MAX_BYTES_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         masked_ff  <= masked_in;
         count_ff   <= count_in;
         len_ff     <= len_in;
         over_ff    <= over_in;
         idx_ff     <= idx_in;
         msg_len_ff <= msg_len_in;
         msg_op_ff  <= msg_op_in;
         if (csr_write && csr_paddr[ADDR_W-1] == REG_MAX_MESSAGE_BYTES[ADDR_W-1]) begin
            max_ff <= csr_pwdata[LEN_W-1:0];
         end
         if (skid_valid_ff) begin
            if (pop) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (!out_valid_ff || pop) begin
            out_valid_ff <= push;
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_ff <= res;
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_has_data     = out_ff.has_data;
   assign rsp_message_type = out_ff.message_type;
   assign rsp_is_control   = out_ff.is_control;
   assign rsp_last         = out_ff.last;
   assign rsp_error        = out_ff.error;

   // skid only fills behind a held output beat
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid)
      else $error("skid register holds a beat while output is empty");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> len_ff != '0)
      else $error("payload phase with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      push && res.error != ERR_NONE |=> phase_ff == PH_FAILED)
      else $error("error result without entering failed state");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FAILED |-> !push)
      else $error("result produced after failure");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FAILED |=> phase_ff == PH_FAILED)
      else $error("failed state left without reset");

endmodule
